// ----- rtl/awsc_pkg.sv -----
`timescale 1ns / 1ps
package awsc_pkg;

   // Block dimensions.
   localparam int WINDOW_DEF   = 20;
   localparam int IDX_W        = 8;
   localparam int SUM_W        = 24;
   localparam int THR_W        = 24;
   localparam int OFS_W        = 12;
   localparam int ACC_W        = 16;
   localparam int ABS_W        = ACC_W + 1;
   localparam int RAD_W        = 32;
   localparam int ROOT_W       = RAD_W / 2;
   localparam int REM_W        = ROOT_W + 3;
   localparam int CNT_W        = 8;
   localparam int ROOT_STEPS   = RAD_W / 2;
   localparam int ITER_W       = $clog2(ROOT_STEPS);
   localparam int OP_W         = 2;
   localparam int CSR_ADDR_W   = 2;
   localparam int CSR_DATA_W   = 24;
   localparam int REQ_DATA_W   = 32;
   localparam int RSP_DATA_W   = 32;

   // Operation codes carried in the request tuser.
   localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
   localparam logic [OP_W-1:0] OP_START  = 2'd1;
   localparam logic [OP_W-1:0] OP_STOP   = 2'd2;

   // Register indexes of the configuration port.
   localparam logic [CSR_ADDR_W-1:0] REG_THRESHOLD = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_X_OFFSET  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_Y_OFFSET  = 2'd2;

   // Register reset values.
   localparam logic [THR_W-1:0] THR_RST  = 24'd20480;
   localparam logic [OFS_W-1:0] XOFS_RST = 12'hF5C;
   localparam logic [OFS_W-1:0] YOFS_RST = 12'd41;

   // Distance is steps * 7 / 10, done as steps * 22939 >> 15 (exact for 8-bit counts).
   localparam int DIST_MUL   = 22939;
   localparam int DIST_SHIFT = 15;
   localparam int DIST_W     = CNT_W + DIST_SHIFT;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic load_squares;
      logic root_init;
      logic root_step;
      logic commit;
   } awsc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic live;
   } awsc_stat_type;

   function automatic logic [CNT_W-1:0] steps_to_metres(input logic [CNT_W-1:0] s);
      logic [DIST_W-1:0] p;
      p = DIST_W'(s) * DIST_W'(DIST_MUL);
      return p[DIST_SHIFT +: CNT_W];
   endfunction

endpackage

// ----- rtl/awsc_ctrl.sv -----
`timescale 1ns / 1ps
module awsc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic [awsc_pkg::OP_W-1:0] req_op,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  awsc_pkg::awsc_stat_type stat,
   output awsc_pkg::awsc_cmd_type  cmd
);
   import awsc_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MUL    = 3'd1;
   localparam logic [2:0] ST_INIT   = 3'd2;
   localparam logic [2:0] ST_ROOT   = 3'd3;
   localparam logic [2:0] ST_COMMIT = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and iteration count.
   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_SAMPLE && stat.live) begin
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_COMMIT;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_INIT;
         end
         ST_INIT: begin
            state_in = ST_ROOT;
            iter_in  = '0;
         end
         ST_ROOT: begin
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(ROOT_STEPS - 1)) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd.load_item    = accept;
      cmd.load_squares = (state_ff == ST_MUL);
      cmd.root_init    = (state_ff == ST_INIT);
      cmd.root_step    = (state_ff == ST_ROOT);
      cmd.commit       = (state_ff == ST_COMMIT) && out_free;
   end

   // The result beat stays valid until it is taken.
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/awsc_dp.sv -----
`timescale 1ns / 1ps
module awsc_dp #(
   parameter int WINDOW = awsc_pkg::WINDOW_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [awsc_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [awsc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [awsc_pkg::OP_W-1:0]         req_op,
   input  logic [awsc_pkg::ACC_W-1:0]        req_x,
   input  logic [awsc_pkg::ACC_W-1:0]        req_y,
   input  awsc_pkg::awsc_cmd_type            cmd,
   output awsc_pkg::awsc_stat_type           stat,
   output logic [awsc_pkg::RSP_DATA_W-1:0]   rsp_data
);
   import awsc_pkg::*;

   // Configuration registers.
   logic [THR_W-1:0] thr_ff;
   logic [OFS_W-1:0] xofs_ff, yofs_ff;

   // Item and magnitude pipeline.
   logic [OP_W-1:0]      op_ff;
   logic [ABS_W-1:0]     ax_ff, ay_ff;
   logic [RAD_W-1:0]     sqx_ff, sqy_ff;
   logic [RAD_W-1:0]     rad_ff, rad_in;
   logic [ROOT_W-1:0]    root_ff, root_in;
   logic [REM_W-1:0]     rem_ff, rem_in;

   // Step counter state.
   logic                 counting_ff, counting_in;
   logic                 calibrated_ff, calibrated_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [SUM_W-1:0]     ref_ff, ref_in;
   logic [CNT_W-1:0]     steps_ff, steps_in;
   logic [CNT_W-1:0]     saved_ff, saved_in;
   logic [RSP_DATA_W-1:0] rsp_ff, rsp_in;

   logic signed [ABS_W-1:0] x_sum, y_sum;
   logic [ABS_W-1:0]        x_abs, y_abs;
   logic [2*ABS_W-1:0]      x_prod, y_prod;
   logic [REM_W-1:0]        rem_sh, trial;
   logic [SUM_W-1:0]        sum_new;
   logic [IDX_W-1:0]        idx_new;
   logic [SUM_W:0]          limit;
   logic                    done, hit;

   assign stat.live = !calibrated_ff || counting_ff;

   // Offset correction and absolute value at the input beat, and squaring.
   always_comb begin
      x_sum = ABS_W'($signed(req_x)) + ABS_W'($signed(xofs_ff));
      y_sum = ABS_W'($signed(req_y)) + ABS_W'($signed(yofs_ff));
      x_abs = x_sum[ABS_W-1] ? ABS_W'(-x_sum) : ABS_W'(x_sum);
      y_abs = y_sum[ABS_W-1] ? ABS_W'(-y_sum) : ABS_W'(y_sum);
      x_prod = (2*ABS_W)'(ax_ff) * (2*ABS_W)'(ax_ff);
      y_prod = (2*ABS_W)'(ay_ff) * (2*ABS_W)'(ay_ff);
   end

   // One radicand bit pair per step of the restoring square root.
   always_comb begin
      rad_in  = rad_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      rem_sh  = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      if (cmd.root_init) begin
         rad_in  = sqx_ff + sqy_ff;
         root_in = '0;
         rem_in  = '0;
      end else if (cmd.root_step) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   // Window, step and mode update when the result is committed.
   always_comb begin
      counting_in   = counting_ff;
      calibrated_in = calibrated_ff;
      idx_in        = idx_ff;
      sum_in        = sum_ff;
      ref_in        = ref_ff;
      steps_in      = steps_ff;
      saved_in      = saved_ff;
      rsp_in        = rsp_ff;
      done          = 1'b0;
      hit           = 1'b0;
      sum_new       = sum_ff + SUM_W'(root_ff);
      idx_new       = idx_ff + 1'b1;
      limit         = (SUM_W + 1)'(ref_ff) + (SUM_W + 1)'(thr_ff);
      if (cmd.commit) begin
         case (op_ff)
            OP_SAMPLE: begin
               if (stat.live) begin
                  if (idx_new == IDX_W'(WINDOW)) begin
                     done = 1'b1;
                     if (calibrated_ff) begin
                        if ((SUM_W + 1)'(sum_new) > limit) begin
                           hit      = 1'b1;
                           steps_in = steps_ff + 1'b1;
                        end
                     end else begin
                        calibrated_in = 1'b1;
                     end
                     ref_in = sum_new;
                     sum_in = '0;
                     idx_in = '0;
                  end else begin
                     sum_in = sum_new;
                     idx_in = idx_new;
                  end
               end
            end
            OP_START: begin
               counting_in = 1'b1;
            end
            OP_STOP: begin
               if (counting_ff) begin
                  saved_in    = steps_ff;
                  steps_in    = '0;
                  sum_in      = '0;
                  idx_in      = '0;
                  counting_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
         rsp_in = {5'b0, counting_in, saved_in, steps_to_metres(steps_in), steps_in,
                   hit, done};
      end
   end

   assign rsp_data = rsp_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= THR_RST;
         xofs_ff <= XOFS_RST;
         yofs_ff <= YOFS_RST;
      end else if (csr_we) begin
         case (csr_addr)
            REG_THRESHOLD: thr_ff  <= csr_wdata[THR_W-1:0];
            REG_X_OFFSET:  xofs_ff <= csr_wdata[OFS_W-1:0];
            REG_Y_OFFSET:  yofs_ff <= csr_wdata[OFS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Counter state.
   always_ff @(posedge clock) begin
      if (reset) begin
         counting_ff   <= 1'b0;
         calibrated_ff <= 1'b0;
         idx_ff        <= '0;
         sum_ff        <= '0;
         ref_ff        <= '0;
         steps_ff      <= '0;
         saved_ff      <= '0;
      end else begin
         counting_ff   <= counting_in;
         calibrated_ff <= calibrated_in;
         idx_ff        <= idx_in;
         sum_ff        <= sum_in;
         ref_ff        <= ref_in;
         steps_ff      <= steps_in;
         saved_ff      <= saved_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff <= req_op;
         ax_ff <= x_abs;
         ay_ff <= y_abs;
      end
      if (cmd.load_squares) begin
         sqx_ff <= x_prod[RAD_W-1:0];
         sqy_ff <= y_prod[RAD_W-1:0];
      end
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      rsp_ff  <= rsp_in;
   end

endmodule

// ----- rtl/accel_window_step_counter.sv -----
`timescale 1ns / 1ps
// Step counter on X/Y accelerometer samples. A request beat carries the operation in
// req_tuser (sample, start, stop) and the raw samples in req_tdata; every request beat
// yields exactly one response beat with the window and step status after that operation.
// A sample that is used passes through squaring, summing the squares, the bit-serial
// square root of the planar magnitude, which resolves one root bit per cycle, and the
// commit before its response is valid; a new request is taken only after the return to
// idle. Start, stop and ignored samples go from their beat straight to the commit. One
// request is worked on at a time; the response register lets the next request be taken
// while the previous response waits, and a response that is not taken holds the next
// request at its commit. Write the configuration registers only while no request is in
// flight.
module accel_window_step_counter #(
   parameter int WINDOW = awsc_pkg::WINDOW_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [awsc_pkg::REQ_DATA_W-1:0]   req_tdata,  // accel_x, accel_y
   input  logic [awsc_pkg::OP_W-1:0]         req_tuser,  // op
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // window_done, step_detected, step_count, distance_m, saved_steps, is_counting, zeros
   output logic [awsc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_we,
   input  logic [awsc_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [awsc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import awsc_pkg::*;

   awsc_cmd_type  cmd;
   awsc_stat_type stat;

   awsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   awsc_dp #(
      .WINDOW (WINDOW)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_op    (req_tuser),
      .req_x     (req_tdata[ACC_W-1:0]),
      .req_y     (req_tdata[2*ACC_W-1:ACC_W]),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_tdata)
   );

endmodule

// ----- rtl/awsc_checker.sv -----
`timescale 1ns / 1ps
module awsc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [awsc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import awsc_pkg::*;

   // Response fields.
   logic             done, hit, counting;
   logic [CNT_W-1:0] steps, metres;

   assign done     = rsp_tdata[0];
   assign hit      = rsp_tdata[1];
   assign steps    = rsp_tdata[2 +: CNT_W];
   assign metres   = rsp_tdata[2 + CNT_W +: CNT_W];
   assign counting = rsp_tdata[2 + 3*CNT_W];

   // A stalled response beat holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // One request is worked on at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted back to back");

   // A step is only counted on a completed window while counting.
   a_step_window: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && hit |-> done && counting)
      else $error("step reported outside a counted window");

   // The count is cleared whenever counting is off.
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !counting |-> steps == '0)
      else $error("step count held while idle");

   // The distance never exceeds the step count.
   a_distance: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> metres <= steps)
      else $error("distance larger than step count");

endmodule

bind accel_window_step_counter awsc_checker u_awsc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- verif/tb_accel_window_step_counter.sv -----
`timescale 1ns / 1ps
module tb_accel_window_step_counter;
   import awsc_pkg::*;

   localparam int WINDOW = WINDOW_DEF;
   // The op code that the block leaves unused.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   // Quiet cycles before a register write and at the end.
   localparam int SETTLE_CYCLES = 32;
   // Long receiver hold-off that backs the block up.
   localparam int HOLD_CYCLES = 300;
   // Cycles without any beat or write before the run is abandoned.
   localparam int STALL_LIMIT = 5000;

   // Fields of one status beat.
   typedef struct {
      bit             done;
      bit             hit;
      logic [CNT_W-1:0] steps;
      logic [CNT_W-1:0] metres;
      logic [CNT_W-1:0] saved;
      bit             counting;
   } step_status_type;

   // Tracks the step counter state and holds the status beats still to come.
   class step_tracker;
      logic [THR_W-1:0]        threshold;
      logic signed [OFS_W-1:0] x_ofs;
      logic signed [OFS_W-1:0] y_ofs;
      bit                      counting;
      bit                      calibrated;
      logic [IDX_W-1:0]        index;
      logic [SUM_W-1:0]        window_sum;
      logic [SUM_W-1:0]        ref_sum;
      logic [CNT_W-1:0]        steps;
      logic [CNT_W-1:0]        saved;
      step_status_type         status_queue[$];
      int                      errors;

      function new();
         threshold  = THR_RST;
         x_ofs      = XOFS_RST;
         y_ofs      = YOFS_RST;
         counting   = 1'b0;
         calibrated = 1'b0;
         index      = '0;
         window_sum = '0;
         ref_sum    = '0;
         steps      = '0;
         saved      = '0;
         errors     = 0;
      endfunction

      function void set_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] value);
         case (addr)
            REG_THRESHOLD: threshold = value[THR_W-1:0];
            REG_X_OFFSET:  x_ofs = value[OFS_W-1:0];
            REG_Y_OFFSET:  y_ofs = value[OFS_W-1:0];
            default: ;
         endcase
      endfunction

      // Integer square root, one result bit at a time from the top.
      function logic [ROOT_W-1:0] planar_root(longint unsigned rad);
         logic [ROOT_W-1:0] root;
         longint unsigned   trial;
         root = '0;
         for (int b = ROOT_W - 1; b >= 0; b--) begin
            trial = longint'(root) | (64'd1 << b);
            if (trial * trial <= rad) root = trial[ROOT_W-1:0];
         end
         return root;
      endfunction

      // Applies one accepted request and queues the status it should produce.
      // Returns 0 for an ignored sample, a stop while idle and the unused op code.
      function bit apply_request(logic [OP_W-1:0] op, logic signed [ACC_W-1:0] ax,
                                 logic signed [ACC_W-1:0] ay);
         step_status_type st;
         longint          sx;
         longint          sy;
         longint unsigned rad;
         bit              changed;
         st = '{default: 0};
         changed = 1'b1;
         case (op)
            OP_SAMPLE: begin
               if (!calibrated || counting) begin
                  sx = longint'(ax) + longint'(x_ofs);
                  sy = longint'(ay) + longint'(y_ofs);
                  if (sx < 0) sx = -sx;
                  if (sy < 0) sy = -sy;
                  rad = sx * sx + sy * sy;
                  window_sum = window_sum + SUM_W'(planar_root(rad));
                  index = index + 1'b1;
                  if (index == IDX_W'(WINDOW)) begin
                     st.done = 1'b1;
                     // The calibration window only sets the reference.
                     if (calibrated) begin
                        if (longint'(window_sum) > longint'(ref_sum) + longint'(threshold))
                        begin
                           st.hit = 1'b1;
                           steps = steps + 1'b1;
                        end
                     end else begin
                        calibrated = 1'b1;
                     end
                     ref_sum = window_sum;
                     window_sum = '0;
                     index = '0;
                  end
               end else begin
                  changed = 1'b0;
               end
            end
            OP_START: counting = 1'b1;
            OP_STOP: begin
               if (counting) begin
                  saved = steps;
                  steps = '0;
                  window_sum = '0;
                  index = '0;
                  counting = 1'b0;
               end else begin
                  changed = 1'b0;
               end
            end
            default: changed = 1'b0;
         endcase
         st.steps = steps;
         st.metres = CNT_W'((int'(steps) * 7) / 10);
         st.saved = saved;
         st.counting = counting;
         status_queue.push_back(st);
         return changed;
      endfunction

      function void report(string what);
         errors++;
         if (errors <= 10) $display("%t mismatch: %s", $realtime, what);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) report($sformatf("%s expected %0d actual %0d", name, want, got));
      endfunction

      // Checks one status beat against the oldest expectation.
      function void check_status(logic [RSP_DATA_W-1:0] data);
         step_status_type want;
         if (status_queue.size() == 0) begin
            report($sformatf("status beat %h with nothing expected", data));
            return;
         end
         want = status_queue.pop_front();
         compare_field("window_done", want.done, data[0]);
         compare_field("step_detected", want.hit, data[1]);
         compare_field("step_count", want.steps, data[9:2]);
         compare_field("distance_m", want.metres, data[17:10]);
         compare_field("saved_steps", want.saved, data[25:18]);
         compare_field("is_counting", want.counting, data[26]);
      endfunction

      function int pending();
         return status_queue.size();
      endfunction

      function void close();
         if (status_queue.size() != 0)
            report($sformatf("%0d status beats never arrived", status_queue.size()));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // accel_x, accel_y
   logic [OP_W-1:0]       req_tuser = OP_SAMPLE;   // op
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // window_done, step_detected, step_count, distance_m, saved_steps, is_counting, zeros
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = REG_THRESHOLD;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   step_tracker tracker = new();
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          applied_items = 0;
   logic        hold_toggle = 1'b0;
   logic        hold_seen = 1'b0;
   int          hold_left = 0;
   int          stall_cycles = 0;

   accel_window_step_counter #(
      .WINDOW(WINDOW)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Status receiver: checks each beat, stalls at random and holds off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) tracker.check_status(rsp_tdata);
         if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog on cycles in which nothing moves.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_accel_window_step_counter: errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Offers one request beat and waits until it is taken.
   task automatic send_item(logic [OP_W-1:0] op, logic signed [ACC_W-1:0] ax,
                            logic signed [ACC_W-1:0] ay);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {ay, ax};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (tracker.apply_request(op, ax, ay)) applied_items++;
   endtask

   // A sample around the given magnitude level, sometimes fully random.
   task automatic send_sample(int level);
      logic signed [ACC_W-1:0] ax;
      logic signed [ACC_W-1:0] ay;
      if ($urandom_range(0, 7) == 0) begin
         ax = ACC_W'($urandom);
         ay = ACC_W'($urandom);
      end else begin
         ax = ACC_W'(($urandom_range(0, 1) ? level : -level) +
                     int'($urandom_range(0, 511)) - 256);
         ay = ACC_W'(int'($urandom_range(0, 511)) - 256);
      end
      send_item(OP_SAMPLE, ax, ay);
   endtask

   // Lets every expected beat arrive and the block fall quiet.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Presents one register write for a single edge; the caller drops the enable.
   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(posedge clock);
      tracker.set_reg(addr, value);
   endtask

   task automatic configure(logic [THR_W-1:0] thr, logic [OFS_W-1:0] xo,
                            logic [OFS_W-1:0] yo);
      settle();
      write_reg(REG_THRESHOLD, thr);
      write_reg(REG_X_OFFSET, {{(CSR_DATA_W-OFS_W){xo[OFS_W-1]}}, xo});
      write_reg(REG_Y_OFFSET, {{(CSR_DATA_W-OFS_W){yo[OFS_W-1]}}, yo});
      csr_we <= 1'b0;
   endtask

   // Mostly counting sessions of whole windows at random levels, with some noise.
   task automatic run_sessions(int count);
      int target;
      int pick;
      target = applied_items + count;
      while (applied_items < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            send_item(OP_START, ACC_W'($urandom), ACC_W'($urandom));
            repeat ($urandom_range(1, 4)) begin
               pick = $urandom_range(0, 30000);
               repeat (WINDOW) send_sample(pick);
            end
            if ($urandom_range(0, 1)) repeat ($urandom_range(1, WINDOW - 1))
               send_sample($urandom_range(0, 30000));
            if ($urandom_range(0, 1))
               send_item(OP_STOP, ACC_W'($urandom), ACC_W'($urandom));
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 6))
               send_item(OP_W'($urandom_range(0, 3)), ACC_W'($urandom), ACC_W'($urandom));
         end else begin
            // Stop, then samples that an idle block ignores once it is calibrated.
            send_item(OP_STOP, ACC_W'($urandom), ACC_W'($urandom));
            repeat ($urandom_range(1, 5)) send_sample($urandom_range(0, 30000));
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Sender idles more rarely than the receiver; reset register values.
      send_idle_pct = 37;
      recv_idle_pct = 52;
      send_item(OP_STOP, 16'sh0000, 16'sh0000);      // stop while idle
      send_item(OP_UNUSED, 16'sh7FFF, 16'sh8000);    // unused op code
      send_item(OP_SAMPLE, 16'sh0000, 16'sh0000);    // sample before calibration, idle
      send_item(OP_START, 16'shFFFF, 16'shFFFF);     // start before calibration
      send_item(OP_SAMPLE, 16'sh8000, 16'sh8000);
      send_item(OP_SAMPLE, 16'sh7FFF, 16'sh7FFF);
      send_item(OP_SAMPLE, 16'sh8000, 16'sh7FFF);
      send_item(OP_SAMPLE, 16'sh7FFF, 16'sh8000);
      send_item(OP_START, 16'sh0000, 16'sh0000);     // start while counting
      send_item(OP_SAMPLE, 16'sh00A4, 16'shFFD7);    // offsets cancel to zero
      send_item(OP_STOP, 16'sh0000, 16'sh0000);      // stop restarts calibration
      send_item(OP_STOP, 16'sh0000, 16'sh0000);
      send_item(OP_SAMPLE, 16'sh1000, 16'sh0000);
      send_item(OP_SAMPLE, 16'sh0000, 16'shF000);
      send_item(OP_UNUSED, 16'sh0000, 16'sh0000);
      run_sessions(300);

      // Receiver idles more rarely; zero threshold and opposite offset extremes.
      configure('0, 12'h800, 12'h7FF);
      send_idle_pct = 52;
      recv_idle_pct = 37;
      run_sessions(300);

      // No idling; a threshold no window can pass, and a long receiver hold-off.
      configure('1, 12'h7FF, 12'h800);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_toggle <= ~hold_toggle;
      run_sessions(200);

      // No idling; a random moderate threshold and random offsets.
      configure(THR_W'($urandom_range(0, 40000)), OFS_W'($urandom), OFS_W'($urandom));
      run_sessions(300);

      settle();
      tracker.close();
      if (tracker.errors == 0) begin
         $display("tb_accel_window_step_counter: clean");
      end else begin
         $display("tb_accel_window_step_counter: errors");
      end
      $finish;
   end

endmodule
